[sv/wvac_pkg.sv]
`timescale 1ns / 1ps
// Shared types, codes and helpers of the windowed variance / autocovariance engine.
// No dependencies; used by every other file of the block but wvac_div.
package wvac_pkg;

  // Width of the configuration write data (widest register)
  localparam int CFG_W = 11;

  // Reset value of the sequence length register
  localparam logic [10:0] LEN_RESET = 11'd1024;

  // Magnitude cap of a quotient and the largest positive / negative results
  localparam logic [63:0] MAG_CAP = 64'h8000_0000_0000_0000;
  localparam logic [63:0] SAT_POS = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] SAT_NEG = 64'h8000_0000_0000_0000;

  // Lag covariance at or above this magnitude saturates the correlation
  localparam logic [63:0] RATIO_LIMIT = 64'h0001_0000_0000_0000;

  typedef enum logic {
    CMD_WRITE   = 1'b0,
    CMD_COMPUTE = 1'b1
  } cmd_e;

  typedef enum logic [1:0] {
    MODE_SAMPLE_VAR = 2'd0,
    MODE_POP_VAR    = 2'd1,
    MODE_AUTOCOV    = 2'd2,
    MODE_AUTOCORR   = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    STAT_OK         = 2'd0,
    STAT_BAD_WINDOW = 2'd1,
    STAT_BAD_LAG    = 2'd2,
    STAT_ZERO_DIV   = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    CFG_STAT_MODE = 2'd0,
    CFG_LAG       = 2'd1,
    CFG_SEQ_LEN   = 2'd2
  } cfg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MEAN,
    ST_MDIV,
    ST_PAIR,
    ST_PDIV,
    ST_RDIV,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic               cmd;
    logic [2:0]         param_index;
    logic [9:0]         position;
    logic signed [31:0] sample_value;
    logic [9:0]         window_start;
    logic [10:0]        window_count;
    logic signed [31:0] mean_value;
  } in_item_t;

  typedef struct packed {
    logic signed [63:0] result_value;
    logic [1:0]         status;
    logic [2:0]         result_param;
  } out_item_t;

  // Apply a sign to a magnitude and saturate to the signed 64-bit range
  function automatic logic [63:0] to_bits(input logic [63:0] mag, input logic neg);
    logic [63:0] res;
    if (neg) begin
      res = (mag >= SAT_NEG) ? SAT_NEG : (~mag + 64'd1);
    end else begin
      res = (mag > SAT_POS) ? SAT_POS : mag;
    end
    return res;
  endfunction

endpackage

[sv/windowed_variance_autocovariance.sv]
`timescale 1ns / 1ps
// Top level of the windowed variance / autocovariance / autocorrelation engine.
// Depends on wvac_pkg and wvac_div.
//
//   channel | direction | handshake                | transaction
//   in      | input     | in_valid_i / in_stall_o  | write one sample or request a statistic
//   out     | output    | out_valid_o / out_stall_i| one statistic with status and parameter
//   cfg     | input     | cfg_we_i                 | write one configuration register
//
// Each walk reads the sample memory, one word per cycle through its single read port,
// and each 64-bit divide runs one bit per cycle. A request with an error status goes
// straight to the done state. No clearing pass after reset.
// One item is worked at a time; a finished result waits in the output register
// while the next item is accepted.
module windowed_variance_autocovariance #(
  parameter int SEQ_DEPTH  = 1024,
  parameter int NUM_PARAMS = 8
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  wvac_pkg::in_item_t            in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output wvac_pkg::out_item_t           out_data_o,
  input  logic                          cfg_we_i,
  input  logic [1:0]                    cfg_idx_i,
  input  logic [wvac_pkg::CFG_W-1:0]    cfg_wdata_i
);

  localparam int MEM_DEPTH = SEQ_DEPTH * NUM_PARAMS;
  localparam int ADDR_W    = $clog2(MEM_DEPTH);
  localparam int LOG_D     = $clog2(SEQ_DEPTH);
  localparam int ACC_W     = 66 + LOG_D;
  localparam int SUM_W     = 33 + LOG_D;
  localparam int DVD_W     = (ACC_W - 16 > 64) ? (ACC_W - 16) : 64;

  // Configuration registers
  wvac_pkg::mode_e mode_cfg_q;
  logic [9:0]      lag_cfg_q;
  logic [10:0]     len_cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_cfg_q <= wvac_pkg::MODE_SAMPLE_VAR;
      lag_cfg_q  <= '0;
      len_cfg_q  <= wvac_pkg::LEN_RESET;
    end else if (cfg_we_i) begin
      unique case (wvac_pkg::cfg_idx_e'(cfg_idx_i))
        wvac_pkg::CFG_STAT_MODE: mode_cfg_q <= wvac_pkg::mode_e'(cfg_wdata_i[1:0]);
        wvac_pkg::CFG_LAG:       lag_cfg_q  <= cfg_wdata_i[9:0];
        wvac_pkg::CFG_SEQ_LEN:   len_cfg_q  <= cfg_wdata_i[10:0];
        default: ;
      endcase
    end
  end

  // State and latched request
  wvac_pkg::state_e  state_q, state_d;
  wvac_pkg::mode_e   mode_q;
  wvac_pkg::status_e res_status_q;
  logic [2:0]         pidx_q;
  logic [9:0]         start_q;
  logic [10:0]        cnt_q;
  logic [9:0]         lag_q;
  logic signed [32:0] m_q;
  logic               pass2_q;
  logic               go_q;

  // Walk control and pipeline tags
  logic [10:0] idx_q;
  logic        phase_q;
  logic        issue_done_q;
  logic        rv_q, rsec_q, rlast_q;
  logic        dv_q, dsec_q, dlast_q;
  logic        pv_q, plast_q;
  logic [31:0] rdata_q;
  logic signed [32:0] diff_q;
  logic signed [32:0] d1_q;
  logic signed [65:0] p_q;
  logic [ACC_W-1:0]   acc_q;
  logic [SUM_W-1:0]   sum_q;

  // Mode 3 intermediate results and the result being built
  logic [63:0] c0_mag_q;
  logic        c0_neg_q;
  logic [63:0] cl_mag_q;
  logic        rneg_q;
  logic [63:0] res_value_q;

  // Output register
  logic                out_valid_q;
  wvac_pkg::out_item_t out_q;

  // Sample memory
  logic [31:0]       mem_q [MEM_DEPTH];
  logic              mem_we;
  logic [ADDR_W-1:0] wr_addr;
  logic [ADDR_W-1:0] rd_addr;

  // Request decode
  logic [10:0]       eff_len;
  logic [11:0]       win_end;
  logic              pidx_ok;
  logic              in_fire;
  logic              is_compute;
  logic              err_any;
  wvac_pkg::status_e err_status;

  always_comb begin
    eff_len    = (int'(len_cfg_q) > SEQ_DEPTH) ? 11'(SEQ_DEPTH) : len_cfg_q;
    win_end    = 12'(in_data_i.window_start) + 12'(in_data_i.window_count);
    pidx_ok    = int'(in_data_i.param_index) < NUM_PARAMS;
    is_compute = in_data_i.cmd == wvac_pkg::CMD_COMPUTE;
    err_any    = 1'b1;
    if (!pidx_ok || in_data_i.window_count == 11'd0 || win_end > 12'(eff_len)) begin
      err_status = wvac_pkg::STAT_BAD_WINDOW;
    end else if ((mode_cfg_q == wvac_pkg::MODE_AUTOCOV ||
                  mode_cfg_q == wvac_pkg::MODE_AUTOCORR) &&
                 in_data_i.window_count <= 11'(lag_cfg_q)) begin
      err_status = wvac_pkg::STAT_BAD_LAG;
    end else if (mode_cfg_q == wvac_pkg::MODE_SAMPLE_VAR &&
                 in_data_i.window_count == 11'd1) begin
      err_status = wvac_pkg::STAT_ZERO_DIV;
    end else begin
      err_status = wvac_pkg::STAT_OK;
      err_any    = 1'b0;
    end
  end

  // Walk parameters of the current pass
  logic        use_lag;
  logic [10:0] pass_n;
  logic [10:0] pass_dsr;
  logic [9:0]  lag_use;
  logic        in_mean, in_pair;
  logic        issue;
  logic        last_issue;
  logic        mean_end, pair_end;
  logic        pass_start;

  always_comb begin
    use_lag  = mode_q == wvac_pkg::MODE_AUTOCOV ||
               (mode_q == wvac_pkg::MODE_AUTOCORR && pass2_q);
    pass_n   = use_lag ? (cnt_q - 11'(lag_q)) : cnt_q;
    pass_dsr = (mode_q == wvac_pkg::MODE_SAMPLE_VAR) ? (cnt_q - 11'd1) : pass_n;
    lag_use  = use_lag ? lag_q : 10'd0;
    in_mean  = state_q == wvac_pkg::ST_MEAN;
    in_pair  = state_q == wvac_pkg::ST_PAIR;
    last_issue = (idx_q == pass_n - 11'd1) && (in_mean || phase_q);
    mean_end = in_mean && rv_q && rlast_q;
    pair_end = in_pair && pv_q && plast_q;
  end

  // Divider and its operand selection
  logic             div_done;
  logic [DVD_W-1:0] div_quot;
  logic [DVD_W-1:0] div_dvd;
  logic [63:0]      div_dsr;
  logic             acc_neg;
  logic [ACC_W-1:0] acc_mag;
  logic             sum_neg;
  logic [SUM_W-1:0] sum_mag;
  logic             pq_hi;
  logic [63:0]      pq_mag;
  logic             cl_big;
  logic             rneg_now;

  always_comb begin
    acc_neg  = acc_q[ACC_W-1];
    acc_mag  = acc_neg ? (~acc_q + ACC_W'(1)) : acc_q;
    sum_neg  = sum_q[SUM_W-1];
    sum_mag  = sum_neg ? (~sum_q + SUM_W'(1)) : sum_q;
    pq_hi    = |(div_quot >> 64);
    pq_mag   = (pq_hi || div_quot[63:0] > wvac_pkg::MAG_CAP) ? wvac_pkg::MAG_CAP
                                                             : div_quot[63:0];
    cl_big   = pq_mag >= wvac_pkg::RATIO_LIMIT;
    rneg_now = (c0_neg_q != acc_neg) && (pq_mag != 64'd0);
    div_dvd  = '0;
    div_dsr  = '0;
    case (state_q)
      wvac_pkg::ST_MDIV: begin
        div_dvd = DVD_W'(sum_mag);
        div_dsr = 64'(cnt_q);
      end
      wvac_pkg::ST_PDIV: begin
        div_dvd = DVD_W'(acc_mag >> 16);
        div_dsr = 64'(pass_dsr);
      end
      wvac_pkg::ST_RDIV: begin
        div_dvd = DVD_W'({cl_mag_q[47:0], 16'h0000});
        div_dsr = c0_mag_q;
      end
      default: ;
    endcase
  end

  wvac_div #(
    .DVD_W (DVD_W)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (go_q),
    .dividend_i (div_dvd),
    .divisor_i  (div_dsr),
    .done_o     (div_done),
    .quotient_o (div_quot)
  );

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      wvac_pkg::ST_IDLE: begin
        if (in_valid_i && is_compute) begin
          if (err_any) begin
            state_d = wvac_pkg::ST_DONE;
          end else if (mode_cfg_q == wvac_pkg::MODE_AUTOCORR) begin
            state_d = wvac_pkg::ST_MEAN;
          end else begin
            state_d = wvac_pkg::ST_PAIR;
          end
        end
      end
      wvac_pkg::ST_MEAN: if (mean_end) state_d = wvac_pkg::ST_MDIV;
      wvac_pkg::ST_MDIV: if (div_done) state_d = wvac_pkg::ST_PAIR;
      wvac_pkg::ST_PAIR: if (pair_end) state_d = wvac_pkg::ST_PDIV;
      wvac_pkg::ST_PDIV: begin
        if (div_done) begin
          if (mode_q != wvac_pkg::MODE_AUTOCORR) begin
            state_d = wvac_pkg::ST_DONE;
          end else if (!pass2_q) begin
            state_d = wvac_pkg::ST_PAIR;
          end else if (c0_mag_q == 64'd0 || cl_big) begin
            state_d = wvac_pkg::ST_DONE;
          end else begin
            state_d = wvac_pkg::ST_RDIV;
          end
        end
      end
      wvac_pkg::ST_RDIV: if (div_done) state_d = wvac_pkg::ST_DONE;
      wvac_pkg::ST_DONE: if (!out_valid_q || !out_stall_i) state_d = wvac_pkg::ST_IDLE;
      default: state_d = wvac_pkg::ST_IDLE;
    endcase
  end

  // State outputs
  always_comb begin
    in_stall_o = state_q != wvac_pkg::ST_IDLE;
    in_fire    = in_valid_i && state_q == wvac_pkg::ST_IDLE;
    issue      = (in_mean || in_pair) && !issue_done_q;
    pass_start = (state_d == wvac_pkg::ST_MEAN || state_d == wvac_pkg::ST_PAIR) &&
                 state_d != state_q;
    mem_we     = in_fire && !is_compute && pidx_ok &&
                 11'(in_data_i.position) < eff_len;
    wr_addr    = ADDR_W'(int'(in_data_i.param_index) * SEQ_DEPTH +
                         int'(in_data_i.position));
    rd_addr    = ADDR_W'(int'(pidx_q) * SEQ_DEPTH + int'(start_q) + int'(idx_q) +
                         (phase_q ? int'(lag_use) : 0));
  end

  // Sample memory: one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[wr_addr] <= in_data_i.sample_value;
    end
    rdata_q <= mem_q[rd_addr];
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= wvac_pkg::ST_IDLE;
      go_q         <= 1'b0;
      pass2_q      <= 1'b0;
      issue_done_q <= 1'b1;
      idx_q        <= '0;
      phase_q      <= 1'b0;
      rv_q         <= 1'b0;
      rsec_q       <= 1'b0;
      rlast_q      <= 1'b0;
      dv_q         <= 1'b0;
      dsec_q       <= 1'b0;
      dlast_q      <= 1'b0;
      pv_q         <= 1'b0;
      plast_q      <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      go_q    <= (state_d == wvac_pkg::ST_MDIV || state_d == wvac_pkg::ST_PDIV ||
                  state_d == wvac_pkg::ST_RDIV) && state_d != state_q;

      // Mark the second pair walk of an autocorrelation
      if (in_fire) begin
        pass2_q <= 1'b0;
      end else if (state_q == wvac_pkg::ST_PDIV && div_done) begin
        pass2_q <= 1'b1;
      end

      // Advance the read walk
      if (pass_start) begin
        idx_q        <= '0;
        phase_q      <= 1'b0;
        issue_done_q <= 1'b0;
      end else if (issue) begin
        if (in_mean || phase_q) begin
          idx_q   <= idx_q + 11'd1;
          phase_q <= 1'b0;
        end else begin
          phase_q <= 1'b1;
        end
        if (last_issue) begin
          issue_done_q <= 1'b1;
        end
      end

      // Tag pipeline alongside the data
      rv_q    <= issue;
      rsec_q  <= phase_q;
      rlast_q <= issue && last_issue;
      dv_q    <= rv_q && in_pair;
      dsec_q  <= rsec_q;
      dlast_q <= rlast_q;
      pv_q    <= dv_q && dsec_q;
      plast_q <= dv_q && dlast_q;

      // Hold the result until taken
      if (state_q == wvac_pkg::ST_DONE && (!out_valid_q || !out_stall_i)) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    // Latch the request
    if (in_fire) begin
      pidx_q       <= in_data_i.param_index;
      start_q      <= in_data_i.window_start;
      cnt_q        <= in_data_i.window_count;
      lag_q        <= lag_cfg_q;
      mode_q       <= mode_cfg_q;
      m_q          <= 33'(in_data_i.mean_value);
      res_status_q <= err_status;
      res_value_q  <= '0;
    end

    // Sample sum for the window mean
    if (pass_start) begin
      sum_q <= '0;
    end else if (rv_q && in_mean) begin
      sum_q <= sum_q + SUM_W'($signed(rdata_q));
    end

    // Deviation, pair product and accumulation
    diff_q <= $signed({rdata_q[31], rdata_q}) - m_q;
    if (dv_q && !dsec_q) begin
      d1_q <= diff_q;
    end
    p_q <= d1_q * diff_q;
    if (pass_start) begin
      acc_q <= '0;
    end else if (pv_q) begin
      acc_q <= acc_q + ACC_W'(p_q);
    end

    // Collect divider results
    if (div_done) begin
      unique case (state_q)
        wvac_pkg::ST_MDIV: begin
          m_q <= sum_neg ? (~div_quot[32:0] + 33'd1) : div_quot[32:0];
        end
        wvac_pkg::ST_PDIV: begin
          if (mode_q != wvac_pkg::MODE_AUTOCORR) begin
            res_value_q <= wvac_pkg::to_bits(pq_mag, acc_neg);
          end else if (!pass2_q) begin
            c0_mag_q <= pq_mag;
            c0_neg_q <= acc_neg;
          end else if (c0_mag_q == 64'd0) begin
            res_status_q <= wvac_pkg::STAT_ZERO_DIV;
          end else if (cl_big) begin
            res_value_q <= wvac_pkg::to_bits(wvac_pkg::MAG_CAP, rneg_now);
          end else begin
            cl_mag_q <= pq_mag;
            rneg_q   <= rneg_now;
          end
        end
        wvac_pkg::ST_RDIV: begin
          res_value_q <= wvac_pkg::to_bits(div_quot[63:0], rneg_q);
        end
        default: ;
      endcase
    end

    // Load the output register
    if (state_q == wvac_pkg::ST_DONE && (!out_valid_q || !out_stall_i)) begin
      out_q.result_value <= res_value_q;
      out_q.status       <= res_status_q;
      out_q.result_param <= pidx_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

[sv/wvac_div.sv]
`timescale 1ns / 1ps
// Iterative restoring unsigned divider, one quotient bit per cycle.
// Uses no package items; instantiated by the top level.
module wvac_div #(
  parameter int DVD_W = 80
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [DVD_W-1:0] dividend_i,
  input  logic [63:0]      divisor_i,
  output logic             done_o,
  output logic [DVD_W-1:0] quotient_o
);

  localparam int CNT_W = $clog2(DVD_W + 1);

  logic             busy_q;
  logic             done_q;
  logic [CNT_W-1:0] cnt_q;
  logic [DVD_W-1:0] dvd_q;
  logic [DVD_W-1:0] quo_q;
  logic [63:0]      rem_q;
  logic [63:0]      dsr_q;
  logic [64:0]      rem_sh;
  logic [64:0]      rem_nx;
  logic             fits;

  // Shift in the next dividend bit and trial-subtract
  always_comb begin
    rem_sh = {rem_q, dvd_q[DVD_W-1]};
    fits   = rem_sh >= {1'b0, dsr_q};
    rem_nx = fits ? (rem_sh - {1'b0, dsr_q}) : rem_sh;
  end

  // Control: load on start, count down one bit per cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CNT_W'(DVD_W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - CNT_W'(1);
        if (cnt_q == CNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Datapath: dividend, remainder and quotient shift registers
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q <= dividend_i;
      dsr_q <= divisor_i;
      rem_q <= '0;
      quo_q <= '0;
    end else if (busy_q) begin
      dvd_q <= {dvd_q[DVD_W-2:0], 1'b0};
      rem_q <= rem_nx[63:0];
      quo_q <= {quo_q[DVD_W-2:0], fits};
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

[sv/wvac_chk.sv]
`timescale 1ns / 1ps
// Port-level checks of the windowed variance engine, bound to the top level.
// Depends on wvac_pkg.
module wvac_chk (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       in_valid_i,
  input logic                       in_stall_o,
  input wvac_pkg::in_item_t         in_data_i,
  input logic                       out_valid_o,
  input logic                       out_stall_i,
  input wvac_pkg::out_item_t        out_data_o,
  input logic                       cfg_we_i,
  input logic [1:0]                 cfg_idx_i,
  input logic [wvac_pkg::CFG_W-1:0] cfg_wdata_i
);

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result changed");

  // Drive a zero value with every error status
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.status != wvac_pkg::STAT_OK |->
      out_data_o.result_value == 64'd0)
    else $error("error status with nonzero value");

  // Raise no result right after a sample write transaction
  a_write_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && in_data_i.cmd == wvac_pkg::CMD_WRITE |=>
      !$rose(out_valid_o))
    else $error("result after a write");

  // Hold off new transactions while a compute is in flight
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && in_data_i.cmd == wvac_pkg::CMD_COMPUTE |=> in_stall_o)
    else $error("input accepted during compute");

endmodule

bind windowed_variance_autocovariance wvac_chk u_wvac_chk (.*);

[bench/wvac_checker.sv]
`timescale 1ns / 1ps
// Checker for the windowed variance / autocovariance engine: watches the input,
// output and configuration ports, predicts each statistic and compares it. Uses wvac_pkg.
module wvac_checker (
  input  logic                       clk_i,
  input  logic                       in_valid_i,
  input  logic                       in_stall_i,
  input  wvac_pkg::in_item_t         in_data_i,
  input  logic                       out_valid_i,
  input  logic                       out_stall_i,
  input  wvac_pkg::out_item_t        out_data_i,
  input  logic                       cfg_we_i,
  input  logic [1:0]                 cfg_idx_i,
  input  logic [wvac_pkg::CFG_W-1:0] cfg_wdata_i,
  output int                         fail_count_o,
  output int                         pending_o
);

  localparam int DEPTH  = 1024;
  localparam int NPARAM = 8;
  localparam logic [127:0] QCAP = 128'h8000_0000_0000_0000;

  logic [31:0]         sample_mem [0:NPARAM*DEPTH-1];
  wvac_pkg::mode_e     mode_q = wvac_pkg::MODE_SAMPLE_VAR;
  logic [9:0]          lag_q  = '0;
  logic [10:0]         len_q  = wvac_pkg::LEN_RESET;
  wvac_pkg::out_item_t stat_q [$];

  assign pending_o = stat_q.size();

  initial fail_count_o = 0;

  task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
    $display("%0t mismatch %s: got %0h want %0h", $realtime, what, got, want);
    fail_count_o++;
  endtask

  // Sum of (x[j]-m)*(x[j+lag]-m) over the window, exact Q32.32
  function automatic logic signed [127:0] lagged_sum(input int base, input int first,
                                                      input int n, input int lag,
                                                      input longint m);
    logic signed [127:0] acc;
    logic signed [127:0] a;
    logic signed [127:0] b;
    acc = '0;
    for (int j = first; j < first + n; j++) begin
      a = longint'($signed(sample_mem[base + j])) - m;
      b = longint'($signed(sample_mem[base + j + lag])) - m;
      acc += a * b;
    end
    return acc;
  endfunction

  // Magnitude of trunc(acc / (d * 2^16)), capped at 2^63; sign of acc in neg
  function automatic logic [63:0] scaled_mag(input logic signed [127:0] acc,
                                             input logic [63:0] d, output logic neg);
    logic [127:0] m;
    logic [127:0] q;
    neg = acc[127];
    m = neg ? -acc : acc;
    q = m / ({64'd0, d} << 16);
    if (q > QCAP) q = QCAP;
    return q[63:0];
  endfunction

  function automatic logic [63:0] signed_sat(input logic [63:0] mag, input logic neg);
    if (neg) return (mag >= 64'h8000_0000_0000_0000) ? 64'h8000_0000_0000_0000 : -mag;
    return (mag > 64'h7FFF_FFFF_FFFF_FFFF) ? 64'h7FFF_FFFF_FFFF_FFFF : mag;
  endfunction

  // Apply one transaction; returns 1 when it yields a statistic
  function automatic bit predict_stat(input wvac_pkg::in_item_t it,
                                      output wvac_pkg::out_item_t res);
    int          eff;
    int          base;
    int          first;
    int          n;
    int          lag;
    longint      total;
    longint      m;
    logic [63:0] mag;
    logic [63:0] c0;
    logic [63:0] cl;
    logic [63:0] q;
    logic        neg;
    logic        n0;
    logic        nl;
    eff   = (len_q < DEPTH) ? len_q : DEPTH;
    base  = it.param_index * DEPTH;
    first = it.window_start;
    n     = it.window_count;
    lag   = lag_q;
    res   = '0;
    if (it.cmd == wvac_pkg::CMD_WRITE) begin
      if (it.position < eff) sample_mem[base + it.position] = it.sample_value;
      return 0;
    end
    res.result_param = it.param_index;
    if (n == 0 || first + n > eff) begin
      res.status = wvac_pkg::STAT_BAD_WINDOW;
    end else if (mode_q >= wvac_pkg::MODE_AUTOCOV && n <= lag) begin
      res.status = wvac_pkg::STAT_BAD_LAG;
    end else if (mode_q == wvac_pkg::MODE_SAMPLE_VAR && n == 1) begin
      res.status = wvac_pkg::STAT_ZERO_DIV;
    end else if (mode_q != wvac_pkg::MODE_AUTOCORR) begin
      m = longint'(it.mean_value);
      if (mode_q == wvac_pkg::MODE_AUTOCOV)
        mag = scaled_mag(lagged_sum(base, first, n - lag, lag, m), n - lag, neg);
      else
        mag = scaled_mag(lagged_sum(base, first, n, 0, m),
                         (mode_q == wvac_pkg::MODE_SAMPLE_VAR) ? n - 1 : n, neg);
      res.status = wvac_pkg::STAT_OK;
      res.result_value = signed_sat(mag, neg);
    end else begin
      // Mean from the window, then lag covariance over lag-0 covariance
      total = 0;
      for (int j = first; j < first + n; j++) total += longint'($signed(sample_mem[base + j]));
      m  = total / longint'(n);
      c0 = scaled_mag(lagged_sum(base, first, n, 0, m), n, n0);
      cl = scaled_mag(lagged_sum(base, first, n - lag, lag, m), n - lag, nl);
      if (c0 == 0) begin
        res.status = wvac_pkg::STAT_ZERO_DIV;
      end else begin
        q = (cl >= wvac_pkg::RATIO_LIMIT) ? 64'h8000_0000_0000_0000 : (cl << 16) / c0;
        res.status = wvac_pkg::STAT_OK;
        res.result_value = signed_sat(q, (n0 != nl) && cl != 0);
      end
    end
    return 1;
  endfunction

  // Track register writes, predict accepted transactions, compare results
  always @(posedge clk_i) begin
    wvac_pkg::out_item_t want;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        wvac_pkg::CFG_STAT_MODE: mode_q = wvac_pkg::mode_e'(cfg_wdata_i[1:0]);
        wvac_pkg::CFG_LAG:       lag_q  = cfg_wdata_i[9:0];
        wvac_pkg::CFG_SEQ_LEN:   len_q  = cfg_wdata_i[10:0];
        default: ;
      endcase
    end
    if (in_valid_i && !in_stall_i) begin
      if (predict_stat(in_data_i, want)) stat_q.push_back(want);
    end
    if (out_valid_i && !out_stall_i) begin
      if (stat_q.size() == 0) begin
        report("unexpected result", out_data_i.result_value, '0);
      end else begin
        want = stat_q.pop_front();
        if (out_data_i.status != want.status)
          report("status", out_data_i.status, want.status);
        if (out_data_i.result_param != want.result_param)
          report("result_param", out_data_i.result_param, want.result_param);
        if (out_data_i.result_value != want.result_value)
          report("result_value", out_data_i.result_value, want.result_value);
      end
    end
  end

endmodule

[bench/tb_windowed_variance_autocovariance.sv]
`timescale 1ns / 1ps
// Testbench top for windowed_variance_autocovariance: clock, reset, stimulus and verdict.
// Depends on wvac_pkg, the block and wvac_checker.
module tb_windowed_variance_autocovariance;

  logic                       clk_i;
  logic                       rst_ni;
  logic                       in_valid;
  logic                       in_stall;
  wvac_pkg::in_item_t         in_data;
  logic                       out_valid;
  logic                       out_stall;
  wvac_pkg::out_item_t        out_data;
  logic                       cfg_we;
  logic [1:0]                 cfg_idx;
  logic [wvac_pkg::CFG_W-1:0] cfg_wdata;
  int                         fail_count;
  int                         pending;

  int unsigned gap_pct   = 0;
  int unsigned stall_pct = 0;
  int          cur_len   = 1024;
  bit          written [0:7][0:1023];

  windowed_variance_autocovariance u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata)
  );

  wvac_checker u_checker (
    .clk_i        (clk_i),
    .in_valid_i   (in_valid),
    .in_stall_i   (in_stall),
    .in_data_i    (in_data),
    .out_valid_i  (out_valid),
    .out_stall_i  (out_stall),
    .out_data_i   (out_data),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_wdata_i  (cfg_wdata),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Random receiver stall
  always @(posedge clk_i) begin
    out_stall <= rst_ni && ($urandom_range(99) < stall_pct);
  end

  // Hard stop
  initial begin
    #30_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  // Send one transaction, keeping valid high into the next one
  task automatic send_item(input wvac_pkg::in_item_t it);
    while ($urandom_range(99) < gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk_i); while (in_stall);
    if (it.cmd == wvac_pkg::CMD_WRITE && it.position < cur_len)
      written[it.param_index][it.position] = 1'b1;
  endtask

  function automatic logic [31:0] pick_sample();
    if ($urandom_range(7) == 0) return $urandom;
    return $urandom_range(32'h0010_0000) - 32'h0008_0000;
  endfunction

  task automatic write_sample(input int p, input int pos, input logic [31:0] v);
    wvac_pkg::in_item_t it;
    it = $bits(wvac_pkg::in_item_t)'({$urandom, $urandom, $urandom, $urandom});
    it.cmd          = wvac_pkg::CMD_WRITE;
    it.param_index  = 3'(p);
    it.position     = 10'(pos);
    it.sample_value = v;
    send_item(it);
  endtask

  // Fill any unwritten entry of a valid window, then request the statistic
  task automatic compute_stat(input int p, input int first, input int n,
                              input logic [31:0] mean);
    wvac_pkg::in_item_t it;
    if (n > 0 && first + n <= cur_len) begin
      for (int j = first; j < first + n; j++)
        if (!written[p][j]) write_sample(p, j, pick_sample());
    end
    it = $bits(wvac_pkg::in_item_t)'({$urandom, $urandom, $urandom, $urandom});
    it.cmd          = wvac_pkg::CMD_COMPUTE;
    it.param_index  = 3'(p);
    it.window_start = 10'(first);
    it.window_count = 11'(n);
    it.mean_value   = mean;
    send_item(it);
  endtask

  // Drain outstanding work, then let the block settle
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  task automatic set_cfg(input wvac_pkg::mode_e mode, input int lag, input int len);
    wait_idle();
    cfg_we    <= 1'b1;
    cfg_idx   <= wvac_pkg::CFG_STAT_MODE;
    cfg_wdata <= wvac_pkg::CFG_W'(mode);
    @(posedge clk_i);
    cfg_idx   <= wvac_pkg::CFG_LAG;
    cfg_wdata <= wvac_pkg::CFG_W'(lag);
    @(posedge clk_i);
    cfg_idx   <= wvac_pkg::CFG_SEQ_LEN;
    cfg_wdata <= wvac_pkg::CFG_W'(len);
    @(posedge clk_i);
    cfg_we    <= 1'b0;
    cur_len = (len < 1024) ? len : 1024;
  endtask

  initial begin
    int lag_tbl [8] = '{0, 1, 2, 7, 1023, 3, 0, 15};
    int len_tbl [8] = '{1024, 300, 64, 1, 2047, 1024, 0, 512};
    int n;
    int first;
    int span;
    int r;
    logic [31:0] mean;
    rst_ni    = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    out_stall = 1'b0;
    cfg_we    = 1'b0;
    cfg_idx   = wvac_pkg::CFG_STAT_MODE;
    cfg_wdata = '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: extremes, every mode, each error status
    set_cfg(wvac_pkg::MODE_SAMPLE_VAR, 0, 1024);
    write_sample(0, 0, 32'h7FFF_FFFF);
    write_sample(0, 1, 32'h8000_0000);
    write_sample(0, 2, 32'h0000_0000);
    write_sample(0, 3, 32'h0000_0001);
    write_sample(0, 4, 32'hFFFF_FFFF);
    write_sample(0, 5, 32'h0001_0000);
    write_sample(7, 1023, 32'h1234_5678);
    compute_stat(0, 0, 6, 32'h0000_0000);
    compute_stat(0, 0, 6, 32'h8000_0000);
    compute_stat(0, 0, 1, 32'h7FFF_FFFF);
    compute_stat(0, 0, 0, 32'h0);
    compute_stat(0, 1, 1024, 32'h0);
    compute_stat(7, 1023, 1, 32'h0);
    compute_stat(0, 1020, 10, 32'h0);
    set_cfg(wvac_pkg::MODE_POP_VAR, 0, 1024);
    compute_stat(7, 1023, 1, 32'h7FFF_FFFF);
    compute_stat(0, 0, 6, 32'hFFFF_0000);
    set_cfg(wvac_pkg::MODE_AUTOCOV, 3, 1024);
    compute_stat(0, 0, 3, 32'h0);
    compute_stat(0, 0, 6, 32'h0);
    set_cfg(wvac_pkg::MODE_AUTOCORR, 1, 1024);
    for (int j = 0; j < 4; j++) write_sample(1, j, 32'h0003_0000);
    compute_stat(1, 0, 4, 32'h0);
    compute_stat(0, 0, 6, 32'h0);
    set_cfg(wvac_pkg::MODE_AUTOCORR, 1023, 2047);
    compute_stat(0, 0, 6, 32'h0);

    // Random phases over modes, lags, lengths and idling patterns
    for (int ph = 0; ph < 8; ph++) begin
      set_cfg(wvac_pkg::mode_e'(ph % 4), lag_tbl[ph], len_tbl[ph]);
      case (ph % 4)
        0: begin gap_pct = 0;  stall_pct = 0;  end
        1: begin gap_pct = 46; stall_pct = 0;  end
        2: begin gap_pct = 0;  stall_pct = 46; end
        default: begin gap_pct = 16; stall_pct = 16; end
      endcase
      for (int k = 0; k < 26; k++) begin
        r = $urandom_range(99);
        if (r < 30) begin
          write_sample($urandom_range(3),
                       ($urandom_range(9) == 0) ? $urandom_range(1023) : $urandom_range(15),
                       pick_sample());
        end else begin
          r = $urandom_range(99);
          if (r < 5) n = 0;
          else if (r < 8) n = $urandom_range(1, 16);
          else n = $urandom_range(1, 12);
          span = (cur_len < 16) ? cur_len : 16;
          if ($urandom_range(9) == 0 || span < n) first = $urandom_range(1023);
          else first = $urandom_range(span - n);
          mean = ($urandom_range(3) == 0) ? $urandom : pick_sample();
          compute_stat($urandom_range(3), first, n, mean);
        end
      end
    end

    wait_idle();
    repeat (200) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

[windowed_variance_autocovariance.f]
sv/wvac_pkg.sv
sv/wvac_div.sv
sv/windowed_variance_autocovariance.sv
sv/wvac_chk.sv
bench/wvac_checker.sv
bench/tb_windowed_variance_autocovariance.sv
